// ===== rtl/brr_pkg.sv =====
`timescale 1ns / 1ps

package brr_pkg;

  // Default depth of the command queue between the front and back parts.
  localparam int BRR_QUEUE_DEPTH = 2;

  localparam int BRR_DATA_W   = 8;
  localparam int BRR_SAMPLE_W = 16;

  // Filter codes from the block header.
  localparam logic [1:0] BRR_FILTER_NONE = 2'd0;
  localparam logic [1:0] BRR_FILTER_ONE  = 2'd1;
  localparam logic [1:0] BRR_FILTER_TWO  = 2'd2;
  localparam logic [1:0] BRR_FILTER_THREE = 2'd3;

  // Ranges at or above this limit saturate the scaled nybble.
  localparam logic [3:0] BRR_RANGE_LIMIT = 4'd13;

  // Command handed from the front part to the back part.
  typedef struct packed {
    logic [BRR_DATA_W-1:0] data;
    logic                  decode;   // data byte with two nybbles
    logic                  clear;    // clear the history first
    logic [3:0]            shift_range;
    logic [1:0]            filter_select;
    logic                  end_bit;
    logic                  loop_bit;
  } brr_cmd_t;

endpackage

// ===== rtl/brr_front.sv =====
`timescale 1ns / 1ps

module brr_front import brr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BRR_DATA_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0]            s_tuser,   // [0] header_flag, [1] restart
  output logic                  push,
  output brr_cmd_t              push_cmd,
  input  logic                  queue_full
);

  logic [3:0] shift_range;
  logic [1:0] filter_select;
  logic       end_bit;
  logic       loop_bit;
  logic       accept;
  logic       is_header;

  assign s_tready  = !queue_full;
  assign accept    = s_tvalid && s_tready;
  assign is_header = s_tuser[0];

  // A header only needs the back part when it also restarts the history.
  assign push = accept && (!is_header || s_tuser[1]);

  always_comb begin
    push_cmd               = '0;
    push_cmd.data          = s_tdata;
    push_cmd.decode        = !is_header;
    push_cmd.clear         = s_tuser[1];
    push_cmd.shift_range   = shift_range;
    push_cmd.filter_select = filter_select;
    push_cmd.end_bit       = end_bit;
    push_cmd.loop_bit      = loop_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_range   <= '0;
      filter_select <= '0;
      end_bit       <= 1'b0;
      loop_bit      <= 1'b0;
    end else if (accept && is_header) begin
      shift_range   <= s_tdata[7:4];
      filter_select <= s_tdata[3:2];
      loop_bit      <= s_tdata[1];
      end_bit       <= s_tdata[0];
    end
  end

endmodule

// ===== rtl/brr_queue.sv =====
`timescale 1ns / 1ps

module brr_queue import brr_pkg::*; #(
  parameter int DEPTH = BRR_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  brr_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output brr_cmd_t head,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  brr_cmd_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/brr_back.sv =====
`timescale 1ns / 1ps

module brr_back import brr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  brr_cmd_t                head,
  input  logic                    empty,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [BRR_SAMPLE_W-1:0] m_tdata,   // [15:0] pcm_sample
  output logic                    m_tlast,   // last
  output logic [1:0]              m_tuser    // [0] block_end, [1] block_loop
);

  // Scale one nybble, add the filter prediction, clamp to 16 bits and
  // keep the low 15 bits.
  function automatic logic [14:0] decode_nyb(
    input logic [3:0]         nyb,
    input logic [3:0]         rng,
    input logic [1:0]         flt,
    input logic signed [14:0] p1,
    input logic signed [14:0] p2
  );
    logic signed [20:0] s;
    logic signed [20:0] scaled;
    logic signed [20:0] p1e;
    logic signed [20:0] p2e;
    logic signed [20:0] acc;
    logic [15:0]        clamped;
    s   = {{17{nyb[3]}}, nyb};
    p1e = {{6{p1[14]}}, p1};
    p2e = {{6{p2[14]}}, p2};
    if (rng < BRR_RANGE_LIMIT) begin
      scaled = (s <<< rng) >>> 1;
    end else begin
      scaled = nyb[3] ? -21'sd2048 : 21'sd0;
    end
    case (flt)
      BRR_FILTER_ONE: begin
        acc = scaled + p1e + ((-p1e) >>> 4);
      end
      BRR_FILTER_TWO: begin
        acc = scaled + (p1e <<< 1) + ((-((p1e <<< 1) + p1e)) >>> 5)
              - p2e + (p2e >>> 4);
      end
      BRR_FILTER_THREE: begin
        acc = scaled + (p1e <<< 1)
              + ((-((p1e <<< 3) + (p1e <<< 2) + p1e)) >>> 6)
              - p2e + (((p2e <<< 1) + p2e) >>> 4);
      end
      default: begin
        acc = scaled;
      end
    endcase
    if (acc > 21'sd32767) begin
      clamped = 16'h7FFF;
    end else if (acc < -21'sd32768) begin
      clamped = 16'h8000;
    end else begin
      clamped = acc[15:0];
    end
    return clamped[14:0];
  endfunction

  logic signed [14:0] history_one;
  logic signed [14:0] history_two;
  logic               phase;        // 0: high nybble next, 1: low nybble next
  logic               out_free;
  logic               do_clear;
  logic               do_sample;
  logic signed [14:0] p1;
  logic signed [14:0] p2;
  logic [3:0]         nyb;
  logic [14:0]        sample;

  assign out_free  = !m_tvalid || m_tready;
  assign do_clear  = !empty && !head.decode;
  assign do_sample = !empty && head.decode && out_free;
  assign pop       = do_clear || (do_sample && phase);

  // The restart clear applies before the high nybble of its byte.
  always_comb begin
    if (head.clear && !phase) begin
      p1 = '0;
      p2 = '0;
    end else begin
      p1 = history_one;
      p2 = history_two;
    end
    nyb    = phase ? head.data[3:0] : head.data[7:4];
    sample = decode_nyb(nyb, head.shift_range, head.filter_select, p1, p2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_one <= '0;
      history_two <= '0;
      phase       <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (do_clear) begin
        history_one <= '0;
        history_two <= '0;
      end else if (do_sample) begin
        history_one <= sample;
        history_two <= p1;
        phase       <= !phase;
      end
      if (do_sample) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_sample) begin
      m_tdata <= {sample, 1'b0};
      m_tlast <= phase;
      m_tuser <= {head.loop_bit, head.end_bit};
    end
  end

endmodule

// ===== rtl/brr_adpcm_decoder.sv =====
`timescale 1ns / 1ps
// A data byte accepted at the input is written into the command queue, and
// the back part registers its high-nybble sample word at the output and then
// its low-nybble one. The single decode unit makes one sample per cycle while
// the output is not stalled; the queue lets the input take bytes meanwhile.
// Reset (rst, synchronous): clears the history, header fields, queue and output.
module brr_adpcm_decoder import brr_pkg::*; #(
  parameter int QUEUE_DEPTH = BRR_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [BRR_DATA_W-1:0]   s_tdata,   // [7:0] data_byte
  input  logic [1:0]              s_tuser,   // [0] header_flag, [1] restart
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [BRR_SAMPLE_W-1:0] m_tdata,   // [15:0] pcm_sample
  output logic                    m_tlast,   // last
  output logic [1:0]              m_tuser    // [0] block_end, [1] block_loop
);

  logic     push;
  brr_cmd_t push_cmd;
  logic     queue_full;
  logic     pop;
  brr_cmd_t head;
  logic     empty;

  brr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  brr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  brr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== tb/brr_adpcm_decoder_test.sv =====
`timescale 1ns / 1ps

module brr_adpcm_decoder_test;
  import brr_pkg::*;

  localparam bit HDR  = 1'b1;
  localparam bit DATA = 1'b0;
  localparam bit CLR  = 1'b1;
  localparam bit KEEP = 1'b0;

  typedef struct packed {
    logic [15:0] pcm;
    logic        last;
    logic        blk_end;
    logic        blk_loop;
  } sample_word_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        hdr;
    logic        clr;
    logic        typed;
    logic [15:0] t0;
    logic [15:0] t1;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [BRR_DATA_W-1:0]   s_tdata = '0;    // [7:0] data_byte
  logic [1:0]              s_tuser = '0;    // [0] header_flag, [1] restart
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [BRR_SAMPLE_W-1:0] m_tdata;         // [15:0] pcm_sample
  logic                    m_tlast;         // last
  logic [1:0]              m_tuser;         // [0] block_end, [1] block_loop

  // Decoder state as the predictor sees it.
  logic signed [14:0] hist_new = '0;
  logic signed [14:0] hist_old = '0;
  logic [3:0]         range_q = '0;
  logic [1:0]         filt_q = '0;
  logic               end_q = 1'b0;
  logic               loop_q = 1'b0;

  sample_word_t expected_q[$];
  sample_word_t want_word;
  stim_row_t    directed_rows[$];

  logic  gaps_on = 1'b1;
  logic  hold = 1'b0;
  logic  random_phase = 1'b0;
  int    rx_pause;
  int    ready_wait = 0;
  int    errors = 0;
  int    bytes_sent = 0;
  int    headers_sent = 0;
  int    restarts_sent = 0;
  int    words_checked = 0;
  logic [3:0]  filters_seen = '0;
  logic [15:0] ranges_seen = '0;

  brr_adpcm_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: %s got %h, expected %h", $time, field, got, want);
    errors++;
  endtask

  // Scales one nybble, adds the filter prediction and shifts the history.
  function automatic logic signed [14:0] decode_nybble(input logic [3:0] nyb);
    int s;
    int p1;
    int p2;
    int acc;
    logic [14:0] w;
    s  = $signed(nyb);
    p1 = hist_new;
    p2 = hist_old;
    if (range_q < BRR_RANGE_LIMIT) begin
      acc = (s * (1 << range_q)) >>> 1;
    end else begin
      acc = (s < 0) ? -2048 : 0;
    end
    case (filt_q)
      BRR_FILTER_ONE: begin
        acc += p1 + ((-p1) >>> 4);
      end
      BRR_FILTER_TWO: begin
        acc += 2 * p1 + ((-3 * p1) >>> 5) - p2 + (p2 >>> 4);
      end
      BRR_FILTER_THREE: begin
        acc += 2 * p1 + ((-13 * p1) >>> 6) - p2 + ((3 * p2) >>> 4);
      end
      default: begin
      end
    endcase
    if (acc > 32767) begin
      acc = 32767;
    end else if (acc < -32768) begin
      acc = -32768;
    end
    // The clamped sum keeps only its low 15 bits.
    w = acc[14:0];
    hist_old = hist_new;
    hist_new = w;
    return w;
  endfunction

  // Updates the predicted state for one accepted byte and queues its samples.
  // Rows with typed values supply the sample themselves.
  task automatic accept_byte(input logic [7:0] b, input logic hdr, input logic clr,
                             input logic typed, input logic [15:0] t0,
                             input logic [15:0] t1);
    sample_word_t wd;
    logic signed [14:0] smp;
    logic [3:0] nyb;
    bytes_sent++;
    if (clr) begin
      restarts_sent++;
      hist_new = '0;
      hist_old = '0;
    end
    if (hdr) begin
      headers_sent++;
      range_q = b[7:4];
      filt_q  = b[3:2];
      loop_q  = b[1];
      end_q   = b[0];
      return;
    end
    filters_seen[filt_q]  = 1'b1;
    ranges_seen[range_q] = 1'b1;
    for (int k = 0; k < 2; k++) begin
      nyb = (k == 0) ? b[7:4] : b[3:0];
      smp = decode_nybble(nyb);
      wd.pcm      = typed ? ((k == 0) ? t0 : t1) : {smp, 1'b0};
      wd.last     = (k == 1);
      wd.blk_end  = end_q;
      wd.blk_loop = loop_q;
      expected_q.insert(expected_q.size(), wd);
    end
  endtask

  // Offers one byte after a random pause, none while gaps are off, and waits for it to be taken.
  // Valid is only lowered when a pause follows, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [7:0] b, input logic hdr, input logic clr,
                           input logic typed = 1'b0, input logic [15:0] t0 = '0,
                           input logic [15:0] t1 = '0);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {clr, hdr};
    do @(posedge clk); while (!s_tready);
    accept_byte(b, hdr, clr, typed, t0, t1);
  endtask

  task automatic add_row(input logic [7:0] b, input logic hdr, input logic clr,
                         input logic typed = 1'b0, input logic [15:0] t0 = '0,
                         input logic [15:0] t1 = '0);
    stim_row_t r;
    r.b = b;
    r.hdr = hdr;
    r.clr = clr;
    r.typed = typed;
    r.t0 = t0;
    r.t1 = t1;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Receiver pacing: a random pause after each word, none while gaps are off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_wait <= 0;
    end else if (hold) begin
      m_tready <= 1'b0;
    end else if (m_tready && m_tvalid) begin
      rx_pause = gaps_on ? $urandom_range(0, 14) : 0;
      ready_wait <= rx_pause;
      m_tready   <= (rx_pause == 0);
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
      m_tready   <= (ready_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("word with nothing pending, pcm_sample", m_tdata, '0);
      end else begin
        want_word = expected_q.pop_front();
        words_checked++;
        if (m_tdata !== want_word.pcm) begin
          report_mismatch("pcm_sample", m_tdata, want_word.pcm);
        end
        if (m_tlast !== want_word.last) begin
          report_mismatch("last", 16'(m_tlast), 16'(want_word.last));
        end
        if (m_tuser[0] !== want_word.blk_end) begin
          report_mismatch("block_end", 16'(m_tuser[0]), 16'(want_word.blk_end));
        end
        if (m_tuser[1] !== want_word.blk_loop) begin
          report_mismatch("block_loop", 16'(m_tuser[1]), 16'(want_word.blk_loop));
        end
      end
    end
  end

  // Long output stall early in the random part so the input side backs up.
  initial begin
    wait (random_phase);
    repeat (50) @(posedge clk);
    hold <= 1'b1;
    repeat (300) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timed out with %0d sample words still pending", expected_q.size());
    $display("brr_adpcm_decoder: mismatch");
    $finish;
  end

  initial begin
    logic [7:0] hb;
    int choice;
    int n;

    // Data before any header runs with range 0 and filter 0.
    add_row(8'h00, DATA, KEEP, 1'b1, 16'h0000, 16'h0000);
    add_row(8'h7F, DATA, KEEP, 1'b1, 16'h0006, 16'hFFFE);
    add_row(8'hC0, HDR,  KEEP);
    add_row(8'h78, DATA, KEEP, 1'b1, 16'h7000, 16'h8000);
    // Ranges of 13 and up saturate to 0 or -2048.
    add_row(8'hD3, HDR,  KEEP);
    add_row(8'h7F, DATA, KEEP, 1'b1, 16'h0000, 16'hF000);
    add_row(8'hF0, HDR,  KEEP);
    add_row(8'h08, DATA, KEEP, 1'b1, 16'h0000, 16'hF000);
    add_row(8'hE2, HDR,  KEEP);
    add_row(8'h80, DATA, KEEP, 1'b1, 16'hF000, 16'h0000);
    // Prediction filters, driven hard enough to clamp.
    add_row(8'hB4, HDR,  CLR);
    add_row(8'h77, DATA, KEEP);
    add_row(8'h7F, DATA, KEEP);
    add_row(8'h88, DATA, KEEP);
    add_row(8'hC9, HDR,  KEEP);
    add_row(8'h77, DATA, KEEP);
    add_row(8'h77, DATA, KEEP);
    add_row(8'h88, DATA, CLR);
    add_row(8'hCE, HDR,  KEEP);
    add_row(8'h77, DATA, KEEP);
    add_row(8'h77, DATA, KEEP);
    add_row(8'h99, DATA, KEEP);
    // Restart on a header clears the history and still latches the header.
    add_row(8'h5D, HDR,  CLR);
    add_row(8'hFF, DATA, KEEP);
    add_row(8'h00, DATA, KEEP);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].b, directed_rows[i].hdr, directed_rows[i].clr,
                directed_rows[i].typed, directed_rows[i].t0, directed_rows[i].t1);
    end

    // Random part: mostly whole blocks, some cut short, some stray bytes.
    random_phase <= 1'b1;
    while (bytes_sent < 525) begin
      gaps_on <= ($urandom_range(0, 2) != 0);
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 3) == 0));
      end else begin
        hb = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) begin
          hb[7:4] = 4'($urandom_range(10, 12));
        end
        send_byte(hb, HDR, ($urandom_range(0, 7) == 0));
        n = (choice == 1) ? $urandom_range(1, 7) : 8;
        for (int i = 0; i < n; i++) begin
          send_byte(8'($urandom_range(0, 255)), DATA, ($urandom_range(0, 31) == 0));
        end
      end
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d bytes sent (%0d headers, %0d with restart), %0d sample words checked",
             bytes_sent, headers_sent, restarts_sent, words_checked);
    $display("filters decoded: %b, ranges decoded: %h", filters_seen, ranges_seen);
    if (errors == 0) begin
      $display("brr_adpcm_decoder: match");
    end else begin
      $display("brr_adpcm_decoder: mismatch");
    end
    $finish;
  end

endmodule
